// ===== sv/ratio_scaler_mul_div_defines.svh =====
// Assertion macros for the ratio scaler RTL, used by rsmd_out.
`ifndef RATIO_SCALER_MUL_DIV_DEFINES_SVH
`define RATIO_SCALER_MUL_DIV_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSMD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsmd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RSMD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsmd: next-cycle check failed");

`endif

// ===== sv/rsmd_pkg.sv =====
// Shared constants and types for the ratio scaler pipeline.
package rsmd_pkg;

  localparam int WORD_BITS     = 16;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int DIV_STEPS     = PROD_BITS;
  localparam int OP_BITS       = 2;
  localparam int IN_DATA_BITS  = ((3 * WORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  localparam logic [OP_BITS-1:0] OP_SIGNED   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_UNSIGNED = 2'd1;
  localparam logic [OP_BITS-1:0] OP_ROUND    = 2'd2;

  // One transaction on its way through the divider stages.
  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic [PROD_BITS-1:0] dvd;
    logic [WORD_BITS-1:0] quot;
    logic [WORD_BITS-1:0] qmag;
    logic                 neg;
    logic                 dz;
  } div_item_t;

endpackage

// ===== sv/ratio_scaler_mul_div.sv =====
// Ratio scaler: pipelined x*p/q with signed, unsigned and rounded modes.
//
// in_tvalid/in_tready/in_tdata/in_tuser carry one operand transaction:
// in_tuser is the opcode, in_tdata holds x, p and q. out_tvalid/out_tready
// carry the result: out_tdata is the low word of the quotient, out_tuser
// flags a zero divisor (the quotient is then zero).
// Pipeline: four operand/multiply/round/magnitude stages, 32 restoring
// divide stages at one quotient bit each, then one output register.
// Throughput: one transaction per cycle while in_tready is high; the divider chain sets the depth.
// Reset clears every valid bit; nothing is in flight afterwards.
// When the receiver stalls, the output register holds its transaction and
// one more lands in a skid slot; the pipeline then freezes and in_tready
// drops until the slot drains. Nothing is lost or repeated.
module ratio_scaler_mul_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // value_in, multiplier, divisor (lowest first)
  input  logic [rsmd_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // opcode
  input  logic [rsmd_pkg::OP_BITS-1:0]         in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // scaled, zero padded
  output logic [rsmd_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  // divide_by_zero
  output logic                                 out_tuser
);

  localparam int W = rsmd_pkg::WORD_BITS;
  localparam int N = rsmd_pkg::DIV_STEPS;

  logic                   adv;
  logic                   stg_v [0:N];
  rsmd_pkg::div_item_t    stg_d [0:N];
  logic [W-1:0]           res;

  assign in_tready = adv;

  rsmd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_tvalid),
    .in_op   (in_tuser),
    .in_x    (in_tdata[W-1:0]),
    .in_p    (in_tdata[2*W-1:W]),
    .in_q    (in_tdata[3*W-1:2*W]),
    .out_v_r (stg_v[0]),
    .out_d_r (stg_d[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_div
    rsmd_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (stg_v[i]),
      .in_d    (stg_d[i]),
      .out_v_r (stg_v[i+1]),
      .out_d_r (stg_d[i+1])
    );
  end

  rsmd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_v     (stg_v[N]),
    .push_d     (stg_d[N]),
    .adv        (adv),
    .out_v_r    (out_tvalid),
    .res_r      (res),
    .dz_r       (out_tuser),
    .out_tready (out_tready)
  );

  assign out_tdata = rsmd_pkg::OUT_DATA_BITS'(res);

endmodule

// ===== sv/rsmd_div_step.sv =====
// One registered restoring-division step: one quotient bit per stage.
module rsmd_div_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_v,
  input  rsmd_pkg::div_item_t in_d,
  output logic                out_v_r,
  output rsmd_pkg::div_item_t out_d_r
);

  logic [rsmd_pkg::WORD_BITS:0]   trial;
  logic [rsmd_pkg::WORD_BITS:0]   diff;
  logic                           ge;
  rsmd_pkg::div_item_t            d_nxt;

  always_comb begin
    trial = {in_d.rem, in_d.dvd[rsmd_pkg::PROD_BITS-1]};
    diff  = trial - {1'b0, in_d.qmag};
    ge    = (trial >= {1'b0, in_d.qmag});
    d_nxt = in_d;
    d_nxt.rem  = ge ? diff[rsmd_pkg::WORD_BITS-1:0] : trial[rsmd_pkg::WORD_BITS-1:0];
    d_nxt.dvd  = {in_d.dvd[rsmd_pkg::PROD_BITS-2:0], 1'b0};
    d_nxt.quot = {in_d.quot[rsmd_pkg::WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/rsmd_front.sv =====
// Operand capture, multiply, rounding offset and sign/magnitude split.
module rsmd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_v,
  input  logic [rsmd_pkg::OP_BITS-1:0]     in_op,
  input  logic [rsmd_pkg::WORD_BITS-1:0]   in_x,
  input  logic [rsmd_pkg::WORD_BITS-1:0]   in_p,
  input  logic [rsmd_pkg::WORD_BITS-1:0]   in_q,
  output logic                             out_v_r,
  output rsmd_pkg::div_item_t              out_d_r
);

  localparam int W = rsmd_pkg::WORD_BITS;
  localparam int P = rsmd_pkg::PROD_BITS;

  // stage 1: operands
  logic                             v1_r;
  logic [rsmd_pkg::OP_BITS-1:0]     op1_r;
  logic [W-1:0]                     x1_r, p1_r, q1_r;

  // stage 2: product
  logic                             v2_r;
  logic [rsmd_pkg::OP_BITS-1:0]     op2_r;
  logic [P-1:0]                     prod2_r;
  logic [W-1:0]                     qmag2_r;
  logic                             qneg2_r, same2_r, dz2_r;

  // stage 3: rounded product
  logic                             v3_r;
  logic                             sgn3_r;
  logic [P-1:0]                     rnd3_r;
  logic [W-1:0]                     qmag3_r;
  logic                             qneg3_r, dz3_r;

  logic                             sgn1;
  logic signed [W:0]                xe, pe;
  logic signed [2*W+1:0]            prod_full;
  logic                             qneg1;
  logic [W-1:0]                     qmag1;
  logic [P-1:0]                     hm;
  logic [P-1:0]                     rnd_nxt;
  logic                             pneg;
  logic [P-1:0]                     pmag;
  rsmd_pkg::div_item_t              d_nxt;

  always_comb begin
    sgn1      = (op1_r != rsmd_pkg::OP_UNSIGNED);
    xe        = {sgn1 & x1_r[W-1], x1_r};
    pe        = {sgn1 & p1_r[W-1], p1_r};
    prod_full = xe * pe;
    qneg1     = sgn1 & q1_r[W-1];
    qmag1     = qneg1 ? -q1_r : q1_r;
  end

  always_comb begin
    hm = P'(qmag2_r[W-1:1]);
    if (op2_r == rsmd_pkg::OP_ROUND) begin
      rnd_nxt = (same2_r == qneg2_r) ? (prod2_r - hm) : (prod2_r + hm);
    end else begin
      rnd_nxt = prod2_r;
    end
  end

  always_comb begin
    pneg       = sgn3_r & rnd3_r[P-1];
    pmag       = pneg ? -rnd3_r : rnd3_r;
    d_nxt.rem  = '0;
    d_nxt.dvd  = pmag;
    d_nxt.quot = '0;
    d_nxt.qmag = qmag3_r;
    d_nxt.neg  = pneg ^ qneg3_r;
    d_nxt.dz   = dz3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= in_v;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r   <= in_op;
      x1_r    <= in_x;
      p1_r    <= in_p;
      q1_r    <= in_q;

      op2_r   <= op1_r;
      prod2_r <= prod_full[P-1:0];
      qmag2_r <= qmag1;
      qneg2_r <= qneg1;
      same2_r <= (x1_r[W-1] == p1_r[W-1]);
      dz2_r   <= (q1_r == '0);

      sgn3_r  <= (op2_r != rsmd_pkg::OP_UNSIGNED);
      rnd3_r  <= rnd_nxt;
      qmag3_r <= qmag2_r;
      qneg3_r <= qneg2_r;
      dz3_r   <= dz2_r;

      out_d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/rsmd_out.sv =====
// Quotient sign fix, output register and skid slot.
`include "ratio_scaler_mul_div_defines.svh"

module rsmd_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push_v,
  input  rsmd_pkg::div_item_t              push_d,
  output logic                             adv,
  output logic                             out_v_r,
  output logic [rsmd_pkg::WORD_BITS-1:0]   res_r,
  output logic                             dz_r,
  input  logic                             out_tready
);

  localparam int W = rsmd_pkg::WORD_BITS;

  logic           skid_v_r;
  logic [W-1:0]   skid_res_r;
  logic           skid_dz_r;
  logic [W-1:0]   res_nxt;
  logic           push;

  assign adv  = !skid_v_r;
  assign push = push_v && adv;

  always_comb begin
    if (push_d.dz) begin
      res_nxt = '0;
    end else begin
      res_nxt = push_d.neg ? -push_d.quot : push_d.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        res_r <= skid_res_r;
        dz_r  <= skid_dz_r;
      end
    end else if (push) begin
      if (out_v_r && !out_tready) begin
        skid_res_r <= res_nxt;
        skid_dz_r  <= push_d.dz;
      end else begin
        res_r <= res_nxt;
        dz_r  <= push_d.dz;
      end
    end
  end

  `RSMD_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r)
  `RSMD_ASSERT_NXT(a_skid_drains, skid_v_r && out_tready, !skid_v_r)
  `RSMD_ASSERT_IMP(a_dz_gives_zero, out_v_r && dz_r, res_r == '0)
  `RSMD_ASSERT_NXT(a_stall_fills_skid, out_v_r && !out_tready && push, skid_v_r)

endmodule
